@@ hdl/tlf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tlf_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_NONBLANK  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_ALL       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SHOW_ENDS        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

    // Character codes
    localparam logic [7:0] CHAR_TAB         = 8'd9;
    localparam logic [7:0] CHAR_NL          = 8'd10;
    localparam logic [7:0] CHAR_SPACE       = 8'd32;
    localparam logic [7:0] CHAR_DOLLAR      = 8'd36;
    localparam logic [7:0] CHAR_ZERO        = 8'd48;
    localparam logic [7:0] CHAR_QUESTION    = 8'd63;
    localparam logic [7:0] CHAR_I           = 8'd73;
    localparam logic [7:0] CHAR_CARET       = 8'd94;
    localparam logic [7:0] CHAR_DEL         = 8'd127;
    localparam logic [7:0] CHAR_FIRST_PRINT = 8'd32;
    localparam logic [7:0] CARET_OFFSET     = 8'd64;

    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } tlf_cfg_t;

    // One classified item, as handed from front to back
    typedef struct packed {
        logic       do_number;
        logic       has_prefix;
        logic [7:0] prefix_char;
        logic [7:0] final_char;
    } tlf_cmd_t;

endpackage

`default_nettype wire

@@ hdl/tlf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tlf_front #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tlf_pkg::tlf_cfg_t          cfg,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 in_byte,
    input  logic                       file_start,
    input  logic                       q_full,
    output logic                       push,
    output tlf_pkg::tlf_cmd_t          cmd,
    output logic [4*NUMBER_DIGITS-1:0] cmd_bcd
);
    import tlf_pkg::*;

    localparam int BCD_W = 4 * NUMBER_DIGITS;

    logic             prev_newline_reg, prev_newline_next;
    logic [1:0]       blank_run_reg, blank_run_next;
    logic [BCD_W-1:0] line_bcd_reg, line_bcd_next;

    logic             accept;
    logic             pn;
    logic [1:0]       br;
    logic             is_nl;
    logic             squeeze_hit;
    logic             drop;
    logic [BCD_W-1:0] bcd_inc;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;
    assign is_nl    = (in_byte == CHAR_NL);

    // A file start clears the line context before this byte is looked at
    assign pn = file_start ? 1'b1 : prev_newline_reg;
    assign br = file_start ? 2'd0 : blank_run_reg;

    assign squeeze_hit = cfg.squeeze_blank && is_nl && pn;

    always_comb
    begin
        blank_run_next = 2'd0;
        if (squeeze_hit)
        begin
            blank_run_next = (br < 2'd2) ? br + 2'd1 : br;
        end
    end

    assign drop = squeeze_hit && (blank_run_next > 2'd1);

    // Classify
    always_comb
    begin
        cmd.do_number   = cfg.number_nonblank ? (pn && !is_nl) : (pn && cfg.number_all);
        cmd.has_prefix  = 1'b0;
        cmd.prefix_char = CHAR_CARET;
        cmd.final_char  = in_byte;
        if (cfg.show_tabs && in_byte == CHAR_TAB)
        begin
            cmd.has_prefix = 1'b1;
            cmd.final_char = CHAR_I;
        end
        else if (cfg.show_ends && is_nl)
        begin
            cmd.has_prefix  = 1'b1;
            cmd.prefix_char = CHAR_DOLLAR;
        end
        else if (cfg.show_nonprinting)
        begin
            if (in_byte < CHAR_TAB || (in_byte > CHAR_NL && in_byte < CHAR_FIRST_PRINT))
            begin
                cmd.has_prefix = 1'b1;
                cmd.final_char = in_byte + CARET_OFFSET;
            end
            else if (in_byte == CHAR_DEL)
            begin
                cmd.has_prefix = 1'b1;
                cmd.final_char = CHAR_QUESTION;
            end
        end
    end

    // Saturating BCD increment
    always_comb
    begin
        logic       carry;
        logic       all_nines;
        logic [3:0] d;
        carry     = 1'b1;
        all_nines = 1'b1;
        bcd_inc   = line_bcd_reg;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            d = line_bcd_reg[4*i +: 4];
            all_nines = all_nines && (d == 4'd9);
            if (carry)
            begin
                bcd_inc[4*i +: 4] = (d == 4'd9) ? 4'd0 : d + 4'd1;
            end
            carry = carry && (d == 4'd9);
        end
        if (all_nines)
        begin
            bcd_inc = line_bcd_reg;
        end
    end

    always_comb
    begin
        prev_newline_next = prev_newline_reg;
        line_bcd_next     = line_bcd_reg;
        if (accept)
        begin
            prev_newline_next = drop ? pn : is_nl;
            if (!drop && cmd.do_number)
            begin
                line_bcd_next = bcd_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_newline_reg <= 1'b1;
            blank_run_reg    <= 2'd0;
            line_bcd_reg     <= BCD_W'(1);
        end
        else
        begin
            prev_newline_reg <= prev_newline_next;
            line_bcd_reg     <= line_bcd_next;
            if (accept)
            begin
                blank_run_reg <= blank_run_next;
            end
        end
    end

    assign push    = accept && !drop;
    assign cmd_bcd = line_bcd_reg;

endmodule

`default_nettype wire

@@ hdl/tlf_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tlf_queue #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             rvalid,
    output logic [WIDTH-1:0] rdata
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tlf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tlf_back #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  tlf_pkg::tlf_cmd_t          q_cmd,
    input  logic [4*NUMBER_DIGITS-1:0] q_bcd,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 out_byte,
    output logic                       last_of_run
);
    import tlf_pkg::*;

    localparam int POS_TAB    = NUMBER_DIGITS;
    localparam int POS_PREFIX = NUMBER_DIGITS + 1;
    localparam int POS_FINAL  = NUMBER_DIGITS + 2;
    localparam int POS_W      = $clog2(NUMBER_DIGITS + 3);
    localparam int DIG_IW     = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             first_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             last_reg;

    logic [NUMBER_DIGITS-1:0][3:0] digits;
    logic [NUMBER_DIGITS-1:0]      zero_above;
    logic [POS_W-1:0]              start_pos;
    logic [POS_W-1:0]              cur_pos;
    logic [POS_W-1:0]              idx_full;
    logic [DIG_IW-1:0]             digit_idx;
    logic                          advance;
    logic                          emit;
    logic [7:0]                    beat_char;
    logic                          beat_last;

    assign digits = q_bcd;

    // zero_above[i]: digit i and every digit above it are zero
    always_comb
    begin
        logic z;
        z = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            z = z && (digits[i] == 4'd0);
            zero_above[i] = z;
        end
    end

    always_comb
    begin
        if (q_cmd.do_number)
        begin
            start_pos = '0;
        end
        else if (q_cmd.has_prefix)
        begin
            start_pos = POS_W'(POS_PREFIX);
        end
        else
        begin
            start_pos = POS_W'(POS_FINAL);
        end
    end

    assign cur_pos   = first_reg ? start_pos : pos_reg;
    assign idx_full  = POS_W'(NUMBER_DIGITS - 1) - cur_pos;
    assign digit_idx = idx_full[DIG_IW-1:0];

    always_comb
    begin
        beat_last = 1'b0;
        pos_next  = cur_pos + POS_W'(1);
        if (cur_pos == POS_W'(POS_FINAL))
        begin
            beat_char = q_cmd.final_char;
            beat_last = 1'b1;
        end
        else if (cur_pos == POS_W'(POS_PREFIX))
        begin
            beat_char = q_cmd.prefix_char;
            pos_next  = POS_W'(POS_FINAL);
        end
        else if (cur_pos == POS_W'(POS_TAB))
        begin
            beat_char = CHAR_TAB;
            pos_next  = q_cmd.has_prefix ? POS_W'(POS_PREFIX) : POS_W'(POS_FINAL);
        end
        else if (digit_idx != '0 && zero_above[digit_idx])
        begin
            beat_char = CHAR_SPACE;
        end
        else
        begin
            beat_char = CHAR_ZERO + {4'd0, digits[digit_idx]};
        end
    end

    assign advance = !out_valid_reg || !out_stall;
    assign emit    = advance && q_valid;
    assign q_pop   = emit && beat_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b1;
            pos_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= emit;
            end
            if (emit)
            begin
                first_reg <= beat_last;
                pos_reg   <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= beat_char;
            last_reg     <= beat_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

@@ hdl/text_stream_line_formatter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Beat payload
// -------   ---------  -------------------  -----------------------------
// in        sink       in_valid / in_stall  in_byte[7:0], file_start
// out       source     out_valid/out_stall  out_byte[7:0], last_of_run
// cfg       sink       cfg_valid/cfg_ready  cfg_index[2:0], cfg_data
//
// Items that yield one beat each stream back to back while out_stall is low.
// An item that yields n beats holds the back-end sequencer for all n beats,
// n up to NUMBER_DIGITS + 3 (number, tab, caret or dollar, character).
// A squeezed newline is taken by the front end and yields no beat.
// The front end keeps taking items until the two-entry command queue fills;
// out_stall backs up the output register and sequencer, then queue and input.
// Reset clears all options, sets the line counter to one and the line
// context to "after newline"; cfg_ready is always high.
module text_stream_line_formatter_top #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       file_start,
    // output stream
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [tlf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic       cfg_data
);
    import tlf_pkg::*;

    localparam int BCD_W   = 4 * NUMBER_DIGITS;
    localparam int ENTRY_W = $bits(tlf_cmd_t) + BCD_W;
    localparam int Q_DEPTH = 2;

    tlf_cfg_t         cfg_reg;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    tlf_cmd_t         front_cmd;
    logic [BCD_W-1:0] front_bcd;
    tlf_cmd_t         head_cmd;
    logic [BCD_W-1:0] head_bcd;

    // Configuration is always accepted; unknown indexes drop the write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NUMBER_NONBLANK:  cfg_reg.number_nonblank  <= cfg_data;
                REG_NUMBER_ALL:       cfg_reg.number_all       <= cfg_data;
                REG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= cfg_data;
                REG_SHOW_ENDS:        cfg_reg.show_ends        <= cfg_data;
                REG_SHOW_TABS:        cfg_reg.show_tabs        <= cfg_data;
                REG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= cfg_data;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front end: track line context and counter, classify each byte
    tlf_front #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .file_start(file_start),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (front_cmd),
        .cmd_bcd   (front_bcd)
    );

    // Command queue: decouple classification from beat generation
    tlf_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({front_cmd, front_bcd}),
        .full  (q_full),
        .pop   (q_pop),
        .rvalid(q_valid),
        .rdata ({head_cmd, head_bcd})
    );

    // Back end: expand each command into output beats
    tlf_back #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (head_cmd),
        .q_bcd      (head_bcd),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last_of_run(last_of_run)
    );

    // A taken beat that does not close its run means the same command is
    // still at the queue head, so a further beat must follow at once.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_run) |=> out_valid)
        else $error("output run broken before its last beat");

    // The front end must never push into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    // A pop only happens on a beat that closes a run.
    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_valid && last_of_run))
        else $error("command popped without a closing beat");

endmodule

`default_nettype wire

@@ tb/text_stream_line_formatter_top_tb.sv @@
`timescale 1ns / 1ps

module text_stream_line_formatter_top_tb;
    import tlf_pkg::*;

    localparam int DIGITS       = 6;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 9;
    // Worst item: DIGITS number chars, tab, caret, char. Leave room for
    // a squeezed newline still in the front end and the command queue.
    localparam int SETTLE       = 4 * (DIGITS + 3) + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 200;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_SETS  = 5;
    localparam int ITEMS_PER_SET = 46;

    // Register indexes past the last option; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [7:0] CHAR_A_LOWER = 8'h61;
    localparam logic [7:0] CHAR_A_UPPER = 8'h41;
    localparam logic [7:0] CHAR_X_LOWER = 8'h78;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_BS      = 8'h08;
    localparam logic [7:0] CHAR_VT      = 8'h0B;
    localparam logic [7:0] CHAR_US      = 8'h1F;
    localparam logic [7:0] CHAR_LAST_PRINT = 8'h7E;
    localparam logic [7:0] CHAR_HIGH_FIRST = 8'h80;
    localparam logic [7:0] CHAR_HIGH_FE = 8'hFE;
    localparam logic [7:0] CHAR_HIGH_FF = 8'hFF;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } out_beat_t;

    // Predicts the formatted output of every accepted byte and checks
    // each output beat against the oldest predicted one.
    class line_format_scoreboard;
        tlf_cfg_t              opts;
        bit                    prev_nl;
        bit [1:0]              blank_run;
        bit [4*DIGITS-1:0]     line_bcd;
        out_beat_t             pending_chars[$];
        int                    errors;

        function new();
            opts      = '0;
            prev_nl   = 1'b1;
            blank_run = 2'd0;
            line_bcd  = 1;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic v);
            case (idx)
                REG_NUMBER_NONBLANK:  opts.number_nonblank  = v;
                REG_NUMBER_ALL:       opts.number_all       = v;
                REG_SQUEEZE_BLANK:    opts.squeeze_blank    = v;
                REG_SHOW_ENDS:        opts.show_ends        = v;
                REG_SHOW_TABS:        opts.show_tabs        = v;
                REG_SHOW_NONPRINTING: opts.show_nonprinting = v;
                default: ;
            endcase
        endfunction

        function void format_byte(logic [7:0] b, logic fs);
            logic [7:0] ch;
            logic [7:0] run[$];
            logic       is_nl;
            logic       do_num;
            logic       lead;
            logic       carry;
            logic [3:0] d;
            out_beat_t  beat;
            ch    = b;
            is_nl = (b == CHAR_NL);
            if (fs)
            begin
                prev_nl   = 1'b1;
                blank_run = 2'd0;
            end
            if (opts.squeeze_blank && is_nl && prev_nl)
            begin
                if (blank_run < 2'd2)
                    blank_run++;
                // second and later empty lines vanish entirely
                if (blank_run > 2'd1)
                    return;
            end
            else
                blank_run = 2'd0;

            if (opts.number_nonblank)
                do_num = prev_nl && !is_nl;
            else
                do_num = prev_nl && opts.number_all;

            if (do_num)
            begin
                lead = 1'b1;
                for (int i = DIGITS - 1; i >= 0; i--)
                begin
                    d = line_bcd[4*i +: 4];
                    if (lead && d == 4'd0 && i > 0)
                        run.push_back(CHAR_SPACE);
                    else
                    begin
                        lead = 1'b0;
                        run.push_back(CHAR_ZERO + 8'(d));
                    end
                end
                run.push_back(CHAR_TAB);
                // saturate at all nines, else ripple a BCD increment
                if (line_bcd != {DIGITS{4'h9}})
                begin
                    carry = 1'b1;
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        d = line_bcd[4*i +: 4] + 4'(carry);
                        if (d > 4'd9)
                        begin
                            d     = 4'd0;
                            carry = 1'b1;
                        end
                        else
                            carry = 1'b0;
                        line_bcd[4*i +: 4] = d;
                    end
                end
            end

            if (opts.show_tabs && ch == CHAR_TAB)
            begin
                run.push_back(CHAR_CARET);
                ch = CHAR_I;
            end
            else if (opts.show_ends && is_nl)
                run.push_back(CHAR_DOLLAR);
            else if (opts.show_nonprinting)
            begin
                if (ch < CHAR_TAB || (ch > CHAR_NL && ch < CHAR_FIRST_PRINT))
                begin
                    run.push_back(CHAR_CARET);
                    ch = ch + CARET_OFFSET;
                end
                else if (ch == CHAR_DEL)
                begin
                    run.push_back(CHAR_CARET);
                    ch = CHAR_QUESTION;
                end
            end
            run.push_back(ch);

            foreach (run[k])
            begin
                beat.ch   = run[k];
                beat.last = (k == run.size() - 1);
                pending_chars.push_back(beat);
            end
            prev_nl = is_nl;
        endfunction

        function void check_beat(logic [7:0] ch, logic last);
            out_beat_t want;
            if (pending_chars.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch: unexpected beat out_byte=%h last_of_run=%b", ch, last);
                return;
            end
            want = pending_chars.pop_front();
            if (want.ch !== ch || want.last !== last)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch: out_byte exp %h got %h, last_of_run exp %b got %b",
                             want.ch, ch, want.last, last);
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             in_byte;
    logic                   file_start;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             out_byte;
    logic                   last_of_run;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic                   cfg_data;

    line_format_scoreboard sb;
    int burst_left;
    int gap_max;
    bit hold_request;
    int cycles;

    text_stream_line_formatter_top #(
        .NUMBER_DIGITS(DIGITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .file_start (file_start),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last_of_run(last_of_run),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watch all three channels at the edge; values seen here are the ones
    // from before the edge, since every driver uses nonblocking updates.
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
        if (in_valid && !in_stall)
            sb.format_byte(in_byte, file_start);
        if (out_valid && !out_stall)
            sb.check_beat(out_byte, last_of_run);
    end

    // Receiver: switch between randomly chosen stall patterns; on request,
    // hold off for a long stretch so the block backs up into its input.
    initial
    begin
        rx_mode_t rx_mode;
        int       rx_tick;
        int       hold_left;
        rx_mode   = RX_FREE;
        rx_tick   = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_tick++;
            if (rx_tick % 48 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                case (rx_mode)
                    RX_FREE:     out_stall <= 1'b0;
                    RX_LIGHT:    out_stall <= ($urandom_range(0, 99) < 20);
                    RX_HEAVY:    out_stall <= ($urandom_range(0, 99) < 60);
                    RX_PERIODIC: out_stall <= (rx_tick % 5 >= 2);
                    default:     out_stall <= 1'b0;
                endcase
        end
    end

    // Watchdog: end the run if traffic never settles
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Offer one byte; open a new burst after a random gap when the
    // current one runs out. Return right after the accepting edge.
    task automatic offer(input logic [7:0] b, input logic fs);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        in_byte    <= b;
        file_start <= fs;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Leave cfg_valid high; the caller drops it after the last write
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_options(input tlf_cfg_t o, input bit poke_spare);
        if (poke_spare)
        begin
            cfg_write(REG_SPARE_6, 1'b1);
            cfg_write(REG_SPARE_7, 1'b1);
        end
        cfg_write(REG_NUMBER_NONBLANK, o.number_nonblank);
        cfg_write(REG_NUMBER_ALL, o.number_all);
        cfg_write(REG_SQUEEZE_BLANK, o.squeeze_blank);
        cfg_write(REG_SHOW_ENDS, o.show_ends);
        cfg_write(REG_SHOW_TABS, o.show_tabs);
        cfg_write(REG_SHOW_NONPRINTING, o.show_nonprinting);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait out every predicted beat, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Text-like byte: mostly printable, with newlines, tabs, controls,
    // delete and high bytes mixed in
    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'($urandom_range(CHAR_SPACE, CHAR_LAST_PRINT));
        else if (r < 70)
            return CHAR_NL;
        else if (r < 77)
            return CHAR_TAB;
        else if (r < 85)
            return 8'($urandom_range(CHAR_NUL, CHAR_US));
        else if (r < 89)
            return CHAR_DEL;
        else
            return 8'($urandom_range(CHAR_HIGH_FIRST, CHAR_HIGH_FF));
    endfunction

    initial
    begin
        tlf_cfg_t opts;
        int       sent;
        int       run_len;
        sb           = new();
        burst_left   = 0;
        gap_max      = 4;
        hold_request = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_byte    <= 8'h00;
        file_start <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_NUMBER_NONBLANK;
        cfg_data   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Every option on: non-blank numbering wins, blank lines squeeze,
        // tab, delete and control bytes go to caret form, high bytes pass
        set_options('1, 1'b0);
        offer(CHAR_A_LOWER, 1'b1);
        offer(CHAR_NL, 1'b0);
        offer(CHAR_NL, 1'b0);
        offer(CHAR_NL, 1'b0);
        offer(CHAR_NL, 1'b0);
        offer(CHAR_TAB, 1'b0);
        offer(CHAR_NUL, 1'b0);
        offer(CHAR_DEL, 1'b0);
        offer(CHAR_HIGH_FF, 1'b0);
        offer(CHAR_HIGH_FIRST, 1'b0);
        offer(CHAR_NL, 1'b0);
        drain();

        // Spare indexes must not touch anything; then non-printing only:
        // tab and newline pass, controls around them get carets
        opts = '0;
        opts.show_nonprinting = 1'b1;
        set_options(opts, 1'b1);
        offer(CHAR_TAB, 1'b0);
        offer(CHAR_NL, 1'b0);
        offer(CHAR_US, 1'b0);
        offer(CHAR_VT, 1'b0);
        offer(CHAR_BS, 1'b0);
        offer(CHAR_HIGH_FE, 1'b0);
        offer(CHAR_A_UPPER, 1'b1);
        offer(CHAR_NL, 1'b0);
        drain();

        // Number every line with squeeze on; a new file resets blank runs
        opts = '0;
        opts.number_all    = 1'b1;
        opts.squeeze_blank = 1'b1;
        set_options(opts, 1'b0);
        offer(CHAR_NL, 1'b0);
        offer(CHAR_NL, 1'b0);
        offer(CHAR_NL, 1'b1);
        offer(CHAR_X_LOWER, 1'b0);
        drain();

        // Random text under a new option set per round; first round with
        // all options off, one round without idle gaps on the input side
        for (int p = 0; p < RANDOM_SETS; p++)
        begin
            opts    = (p == 0) ? tlf_cfg_t'('0)
                               : tlf_cfg_t'(6'($urandom_range(0, 63)));
            gap_max = (p == 1) ? 0 : $urandom_range(2, 8);
            set_options(opts, p == 3);
            sent = 0;
            while (sent < ITEMS_PER_SET)
            begin
                if (p == 2 && sent == 0)
                    hold_request = 1'b1;
                if ($urandom_range(0, 99) < 6)
                begin
                    // run of empty lines to exercise squeezing
                    run_len = $urandom_range(2, 4);
                    repeat (run_len) offer(CHAR_NL, 1'b0);
                    sent += run_len;
                end
                else
                begin
                    offer(text_byte(), $urandom_range(0, 99) < 3);
                    sent++;
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
